[rtl/lpmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lpmc_pkg;

    // pattern codes
    localparam logic [1:0] PAT_CHASER  = 2'd0;
    localparam logic [1:0] PAT_BLINK   = 2'd1;
    localparam logic [1:0] PAT_REVERSE = 2'd2;
    localparam logic [1:0] PAT_BREATHE = 2'd3;

    // button code that never queues an event
    localparam logic [1:0] BUTTON_NONE = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATHE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd5;
    localparam int CFG_DATA_W = 10;

    // configuration reset values
    localparam logic [7:0] DEBOUNCE_RESET = 8'd50;
    localparam logic [9:0] CHASER_RESET   = 10'd500;
    localparam logic [9:0] BLINK_RESET    = 10'd500;
    localparam logic [9:0] REVERSE_RESET  = 10'd250;
    localparam logic [9:0] BREATHE_RESET  = 10'd20;
    localparam logic [6:0] STEP_RESET     = 7'd10;

    // breathing turns around at this level
    localparam logic [8:0] BREATHE_TOP = 9'd255;
    // debounce timer saturation
    localparam logic [7:0] SINCE_MAX   = 8'd255;

    typedef struct packed {
        logic [7:0] debounce_ms;
        logic [9:0] chaser_period_ms;
        logic [9:0] blink_period_ms;
        logic [9:0] reverse_period_ms;
        logic [9:0] breathe_period_ms;
        logic [6:0] level_step;
    } cfg_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] push_data;
    } fifo_req_t;

    typedef struct packed {
        logic       full;
        logic       avail;
        logic [1:0] head_data;
    } fifo_stat_t;

    typedef struct packed {
        logic [3:0] led_drive;
        logic       pwm_enabled;
        logic [8:0] pwm_level;
        logic [1:0] current_pattern;
        logic       press_dropped;
    } result_t;

    // next pattern from current pattern and button event
    function automatic logic [1:0] next_pattern(input logic [1:0] pat, input logic [1:0] evt);
        logic [1:0] res;
        res = PAT_CHASER;
        unique case (pat)
            PAT_CHASER:
            begin
                unique case (evt)
                    2'd0: res = PAT_CHASER;
                    2'd1: res = PAT_REVERSE;
                    2'd2: res = PAT_BLINK;
                    default: res = PAT_BREATHE;
                endcase
            end
            PAT_BLINK:
            begin
                unique case (evt)
                    2'd0: res = PAT_CHASER;
                    2'd1: res = PAT_BLINK;
                    2'd2: res = PAT_REVERSE;
                    default: res = PAT_BREATHE;
                endcase
            end
            PAT_REVERSE:
            begin
                unique case (evt)
                    2'd0: res = PAT_BLINK;
                    2'd1: res = PAT_CHASER;
                    2'd2: res = PAT_REVERSE;
                    default: res = PAT_BREATHE;
                endcase
            end
            default: res = PAT_CHASER;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/lpmc_event_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module lpmc_event_fifo
    import lpmc_pkg::*;
#(
    parameter int DEPTH = 10
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire fifo_req_t  req,
    output fifo_stat_t      stat
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [1:0]       store_reg [0:DEPTH-1];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // status; an empty queue hands the word being pushed straight through
    always_comb
    begin
        stat.full      = (count_reg >= FULL_CNT);
        stat.avail     = (count_reg != '0) || req.push;
        stat.head_data = (count_reg == '0) ? req.push_data : store_reg[head_reg];
    end

    // pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (req.push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        if (req.pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        if (req.push && !req.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!req.push && req.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // event storage, no reset
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            store_reg[tail_reg] <= req.push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("event count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with unequal pointers");

    a_push_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req.push && req.pop |=> count_reg == $past(count_reg))
        else $error("count moved on push with pop");

endmodule

`default_nettype wire

[rtl/lpmc_pattern_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module lpmc_pattern_core
    import lpmc_pkg::*;
#(
    parameter int LED_COUNT = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       step,
    input  wire logic       tick,
    input  wire logic       press,
    input  wire logic [1:0] button_id,
    input  wire fifo_stat_t fifo_stat,
    output fifo_req_t       fifo_req,
    output result_t         result
);

    localparam int LIDX_W = $clog2(LED_COUNT);
    localparam logic [3:0] LED_MASK = 4'((1 << LED_COUNT) - 1);
    localparam logic [LIDX_W-1:0] LAST_LED = LIDX_W'(LED_COUNT - 1);
    localparam logic [LIDX_W-1:0] FWD_RESET = LIDX_W'(1 % LED_COUNT);

    logic [1:0]        pattern_reg, pattern_next;
    logic [9:0]        period_reg, period_next;
    logic [7:0]        since_reg, since_next;
    logic [LIDX_W-1:0] fwd_reg, fwd_next;
    logic [LIDX_W-1:0] rev_reg, rev_next;
    logic              blink_reg, blink_next;
    logic [8:0]        bright_reg, bright_next;
    logic              rising_reg, rising_next;
    logic [3:0]        led_reg, led_next;
    logic [8:0]        pwm_reg, pwm_next;

    logic       accepted;
    logic       real_button;
    logic       dropped;
    logic [9:0] period_len;
    logic       period_end;
    logic [9:0] bright_sum;

    // debounce and queue admission
    always_comb
    begin
        accepted    = press && (since_reg > cfg.debounce_ms);
        real_button = (button_id != BUTTON_NONE);
        dropped     = accepted && real_button && fifo_stat.full;
    end

    // period length of the active pattern and queue requests
    always_comb
    begin
        unique case (pattern_reg)
            PAT_CHASER:  period_len = cfg.chaser_period_ms;
            PAT_BLINK:   period_len = cfg.blink_period_ms;
            PAT_REVERSE: period_len = cfg.reverse_period_ms;
            default:     period_len = cfg.breathe_period_ms;
        endcase
        period_end = tick && (({1'b0, period_reg} + 11'd1) >= {1'b0, period_len});
        fifo_req.push      = step && accepted && real_button && !fifo_stat.full;
        fifo_req.push_data = button_id;
        fifo_req.pop       = step && period_end && fifo_stat.avail;
    end

    // next state for one word
    always_comb
    begin
        pattern_next = pattern_reg;
        period_next  = period_reg;
        since_next   = since_reg;
        fwd_next     = fwd_reg;
        rev_next     = rev_reg;
        blink_next   = blink_reg;
        bright_next  = bright_reg;
        rising_next  = rising_reg;
        led_next     = led_reg;
        pwm_next     = pwm_reg;
        bright_sum   = {1'b0, bright_reg} + {3'b0, cfg.level_step};

        if (accepted)
        begin
            since_next = '0;
        end
        if (tick && (since_next != SINCE_MAX))
        begin
            since_next = since_next + 1'b1;
        end

        if (tick && !period_end)
        begin
            period_next = period_reg + 1'b1;
        end

        if (period_end)
        begin
            period_next = '0;
            if (fifo_stat.avail)
            begin
                pattern_next = next_pattern(pattern_reg, fifo_stat.head_data);
                led_next     = '0;
            end
            // pattern step with the pattern now in force
            unique case (pattern_next)
                PAT_CHASER:
                begin
                    led_next = LED_MASK & (4'b0001 << fwd_reg);
                    fwd_next = (fwd_reg == LAST_LED) ? '0 : fwd_reg + 1'b1;
                end
                PAT_BLINK:
                begin
                    led_next   = blink_reg ? 4'b0000 : LED_MASK;
                    blink_next = !blink_reg;
                end
                PAT_REVERSE:
                begin
                    led_next = LED_MASK & (4'b0001 << rev_reg);
                    rev_next = (rev_reg == '0) ? LAST_LED : rev_reg - 1'b1;
                end
                default:
                begin
                    pwm_next = bright_reg;
                    if (rising_reg)
                    begin
                        bright_next = bright_sum[8:0];
                        if (bright_sum[8:0] >= BREATHE_TOP)
                        begin
                            rising_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (bright_reg > {2'b0, cfg.level_step})
                        begin
                            bright_next = bright_reg - {2'b0, cfg.level_step};
                        end
                        else
                        begin
                            bright_next = '0;
                            rising_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // result word from the updated state
    always_comb
    begin
        result.led_drive       = led_next & LED_MASK;
        result.pwm_enabled     = (pattern_next == PAT_BREATHE);
        result.pwm_level       = (pattern_next == PAT_BREATHE) ? pwm_next : 9'd0;
        result.current_pattern = pattern_next;
        result.press_dropped   = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PAT_CHASER;
            period_reg  <= '0;
            since_reg   <= '0;
            fwd_reg     <= FWD_RESET;
            rev_reg     <= LAST_LED;
            blink_reg   <= 1'b0;
            bright_reg  <= '0;
            rising_reg  <= 1'b1;
            led_reg     <= 4'b0001;
            pwm_reg     <= '0;
        end
        else if (step)
        begin
            pattern_reg <= pattern_next;
            period_reg  <= period_next;
            since_reg   <= since_next;
            fwd_reg     <= fwd_next;
            rev_reg     <= rev_next;
            blink_reg   <= blink_next;
            bright_reg  <= bright_next;
            rising_reg  <= rising_next;
            led_reg     <= led_next;
            pwm_reg     <= pwm_next;
        end
    end

    a_breathe_dark: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_reg == PAT_BREATHE |-> led_reg == 4'b0000)
        else $error("leds lit during breathing");

    a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_req.pop |-> step && tick)
        else $error("event popped without a tick");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        step && dropped |-> !fifo_req.push)
        else $error("press both dropped and queued");

endmodule

`default_nettype wire

[rtl/led_pattern_mode_controller_core.sv]
// LED pattern mode controller.
// Input channel: in_valid / in_stall carry one word of tick, press and
// button_id. A press passes the debounce window and is queued as a mode
// event; at the end of each pattern period one event is taken and selects
// the next pattern, which steps at once.
// Output channel: out_valid / out_stall carry one result word per input
// word: led_drive, pwm_enabled, pwm_level, current_pattern, press_dropped.
// A result word passes one input register, then the pattern step logic
// feeding the result register. Throughput is one word per cycle while
// out_stall is low; the result register and the input register let a
// new word enter while a finished result waits.
// When out_stall is high with a result held, the input register keeps its
// word and in_stall rises once it is occupied.
// Reset clears both channel stages, the queue and the pattern state, and
// loads the register defaults; the event storage itself is not cleared.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
// to be written by the user only while no word is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module led_pattern_mode_controller_core
    import lpmc_pkg::*;
#(
    parameter int EVENT_QUEUE_DEPTH = 10,
    parameter int LED_COUNT = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  tick,
    input  wire logic                  press,
    input  wire logic [1:0]            button_id,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [3:0]                 led_drive,
    output logic                       pwm_enabled,
    output logic [8:0]                 pwm_level,
    output logic [1:0]                 current_pattern,
    output logic                       press_dropped
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic       tick_reg;
    logic       press_reg;
    logic [1:0] button_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    logic       advance;
    fifo_req_t  fifo_req;
    fifo_stat_t fifo_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= DEBOUNCE_RESET;
            cfg_reg.chaser_period_ms  <= CHASER_RESET;
            cfg_reg.blink_period_ms   <= BLINK_RESET;
            cfg_reg.reverse_period_ms <= REVERSE_RESET;
            cfg_reg.breathe_period_ms <= BREATHE_RESET;
            cfg_reg.level_step        <= STEP_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_DEBOUNCE)
            begin
                cfg_reg.debounce_ms <= cfg_data[7:0];
            end
            if (cfg_index == CFG_CHASER)
            begin
                cfg_reg.chaser_period_ms <= cfg_data;
            end
            if (cfg_index == CFG_BLINK)
            begin
                cfg_reg.blink_period_ms <= cfg_data;
            end
            if (cfg_index == CFG_REVERSE)
            begin
                cfg_reg.reverse_period_ms <= cfg_data;
            end
            if (cfg_index == CFG_BREATHE)
            begin
                cfg_reg.breathe_period_ms <= cfg_data;
            end
            if (cfg_index == CFG_STEP)
            begin
                cfg_reg.level_step <= cfg_data[6:0];
            end
        end
    end

    // flow control between the two stages
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            tick_reg   <= tick;
            press_reg  <= press;
            button_reg <= button_id;
        end
    end

    lpmc_pattern_core #(
        .LED_COUNT (LED_COUNT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (advance),
        .tick      (tick_reg),
        .press     (press_reg),
        .button_id (button_reg),
        .fifo_stat (fifo_stat),
        .fifo_req  (fifo_req),
        .result    (result_next)
    );

    lpmc_event_fifo #(
        .DEPTH (EVENT_QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fifo_req),
        .stat  (fifo_stat)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign led_drive       = result_reg.led_drive;
    assign pwm_enabled     = result_reg.pwm_enabled;
    assign pwm_level       = result_reg.pwm_level;
    assign current_pattern = result_reg.current_pattern;
    assign press_dropped   = result_reg.press_dropped;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("held result overwritten");

    a_pwm_off_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.pwm_enabled |-> result_reg.pwm_level == 9'd0)
        else $error("pwm level without pwm");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped word produced no result");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import lpmc_pkg::*;

    localparam int QUEUE_SLOTS = 10;
    localparam int PHASES = 9;
    localparam int PHASE_WORDS = 56;

    // button ids that queue a mode event
    localparam logic [1:0] BTN_A = 2'd0;
    localparam logic [1:0] BTN_B = 2'd1;
    localparam logic [1:0] BTN_C = 2'd2;

    typedef struct packed {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        bit                    w_tick;
        bit                    w_press;
        logic [1:0]            w_button;
        bit                    typed;
        result_t               want;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  tick;
    logic                  press;
    logic [1:0]            button_id;
    logic                  out_valid;
    logic                  out_stall;
    logic [3:0]            led_drive;
    logic                  pwm_enabled;
    logic [8:0]            pwm_level;
    logic [1:0]            current_pattern;
    logic                  press_dropped;

    // outputs sampled mid-cycle, used at the next rising edge
    logic    in_stall_s;
    logic    out_valid_s;
    logic    out_stall_s;
    result_t seen_s;

    // expected result words, oldest first
    result_t pending_leds[$];
    int      fail_count = 0;
    int      words_seen = 0;

    // sender burst control
    int burst_left = 0;
    bit steady = 1'b0;

    // receiver stall control
    int          stall_mode = 0;
    int unsigned cyc_n = 0;

    // shadow of the controller: registers and state
    cfg_t        cfg_copy;
    logic [1:0]  mode_q;
    int unsigned ms_count;
    int unsigned ms_since_press;
    logic [1:0]  ev_ring [QUEUE_SLOTS];
    int unsigned ev_count;
    int unsigned ev_head;
    logic [1:0]  fwd_pos;
    logic [1:0]  rev_pos;
    bit          blink_lit;
    int unsigned glow;
    bit          glow_up;
    logic [3:0]  led_q;
    logic [8:0]  glow_held;

    always #1 clk = ~clk;

    led_pattern_mode_controller_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .tick(tick),
        .press(press),
        .button_id(button_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .led_drive(led_drive),
        .pwm_enabled(pwm_enabled),
        .pwm_level(pwm_level),
        .current_pattern(current_pattern),
        .press_dropped(press_dropped)
    );

    task automatic note_error(input string msg);
        $display("mismatch at result word %0d: %s", words_seen, msg);
        fail_count++;
    endtask

    // advance the shadow by one word and return the result it causes
    task automatic predict_led_word(input bit t, input bit p, input logic [1:0] b,
                                    output result_t r);
        bit          dropped;
        logic [1:0]  evt;
        int unsigned span;
        dropped = 1'b0;

        // press is handled before the tick
        if (p && ms_since_press > cfg_copy.debounce_ms)
        begin
            ms_since_press = 0;
            if (b != BUTTON_NONE)
            begin
                if (ev_count >= QUEUE_SLOTS)
                    dropped = 1'b1;
                else
                begin
                    ev_ring[(ev_head + ev_count) % QUEUE_SLOTS] = b;
                    ev_count++;
                end
            end
        end

        if (t)
        begin
            if (ms_since_press < SINCE_MAX)
                ms_since_press++;
            case (mode_q)
                PAT_CHASER:  span = cfg_copy.chaser_period_ms;
                PAT_BLINK:   span = cfg_copy.blink_period_ms;
                PAT_REVERSE: span = cfg_copy.reverse_period_ms;
                default:     span = cfg_copy.breathe_period_ms;
            endcase
            if (ms_count + 1 >= span)
            begin
                ms_count = 0;
                // period end: take one event and pick the next pattern
                if (ev_count > 0)
                begin
                    evt = ev_ring[ev_head];
                    ev_head = (ev_head + 1) % QUEUE_SLOTS;
                    ev_count--;
                    case ({mode_q, evt})
                        {PAT_CHASER, BTN_B}:  mode_q = PAT_REVERSE;
                        {PAT_CHASER, BTN_C}:  mode_q = PAT_BLINK;
                        {PAT_BLINK, BTN_B}:   mode_q = PAT_BLINK;
                        {PAT_BLINK, BTN_C}:   mode_q = PAT_REVERSE;
                        {PAT_REVERSE, BTN_A}: mode_q = PAT_BLINK;
                        {PAT_REVERSE, BTN_C}: mode_q = PAT_REVERSE;
                        default:
                            mode_q = (evt == BUTTON_NONE && mode_q != PAT_BREATHE)
                                     ? PAT_BREATHE : PAT_CHASER;
                    endcase
                    led_q = 4'b0000;
                    if (mode_q == PAT_BREATHE)
                        glow_held = 9'd0;
                end
                // the active pattern steps once
                case (mode_q)
                    PAT_CHASER:
                    begin
                        led_q = 4'b0001 << fwd_pos;
                        fwd_pos = fwd_pos + 2'd1;
                    end
                    PAT_BLINK:
                    begin
                        led_q = blink_lit ? 4'b0000 : 4'b1111;
                        blink_lit = !blink_lit;
                    end
                    PAT_REVERSE:
                    begin
                        led_q = 4'b0001 << rev_pos;
                        rev_pos = rev_pos - 2'd1;
                    end
                    default:
                    begin
                        glow_held = glow[8:0];
                        if (glow_up)
                        begin
                            glow = (glow + cfg_copy.level_step) % 512;
                            if (glow >= BREATHE_TOP)
                                glow_up = 1'b0;
                        end
                        else
                        begin
                            glow = (glow > cfg_copy.level_step)
                                   ? glow - cfg_copy.level_step : 0;
                            if (glow == 0)
                                glow_up = 1'b1;
                        end
                    end
                endcase
            end
            else
                ms_count++;
        end

        r.led_drive = led_q;
        r.pwm_enabled = (mode_q == PAT_BREATHE);
        r.pwm_level = r.pwm_enabled ? glow_held : 9'd0;
        r.current_pattern = mode_q;
        r.press_dropped = dropped;
    endtask

    // register write, one per edge; the caller lowers cfg_write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_DEBOUNCE: cfg_copy.debounce_ms = val[7:0];
            CFG_CHASER:   cfg_copy.chaser_period_ms = val;
            CFG_BLINK:    cfg_copy.blink_period_ms = val;
            CFG_REVERSE:  cfg_copy.reverse_period_ms = val;
            CFG_BREATHE:  cfg_copy.breathe_period_ms = val;
            CFG_STEP:     cfg_copy.level_step = val[6:0];
            default: ;
        endcase
    endtask

    // offer one word in bursts with random gaps, hold it until taken
    task automatic send_word(input bit t, input bit p, input logic [1:0] b,
                             input bit typed, input result_t want);
        int      gap;
        result_t pred;
        cfg_write <= 1'b0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        tick <= t;
        press <= p;
        button_id <= b;
        @(posedge clk);
        while (in_stall_s)
            @(posedge clk);
        predict_led_word(t, p, b, pred);
        pending_leds.push_back(typed ? want : pred);
    endtask

    // stop sending and wait until every expected word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_leds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic script_row_t word_row(bit t, bit p, logic [1:0] b);
        script_row_t r;
        r = '0;
        r.w_tick = t;
        r.w_press = p;
        r.w_button = b;
        return r;
    endfunction

    // rows whose result is plain: still in the chaser, nothing dropped
    function automatic script_row_t known_row(bit t, bit p, logic [1:0] b, logic [3:0] leds);
        script_row_t r;
        r = word_row(t, p, b);
        r.typed = 1'b1;
        r.want = '{leds, 1'b0, 9'd0, PAT_CHASER, 1'b0};
        return r;
    endfunction

    function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        script_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [9:0] pick_period(int ph);
        if (ph == 1)
            return 10'd1;
        if (ph == 3)
            return 10'd1023;
        if ($urandom_range(0, 7) == 0)
            return 10'($urandom_range(8, 1023));
        return 10'($urandom_range(0, 5));
    endfunction

    // mid-cycle sampling of everything the checks look at
    always @(negedge clk)
    begin
        in_stall_s <= in_stall;
        out_valid_s <= out_valid;
        out_stall_s <= out_stall;
        seen_s <= '{led_drive, pwm_enabled, pwm_level, current_pattern, press_dropped};
    end

    // receiver stall: free flow, random, or long regular stalls
    always @(posedge clk)
    begin
        cyc_n++;
        if (cyc_n % 128 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ((cyc_n % 13) < 7);
        endcase
    end

    // compare each taken result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid_s && !out_stall_s)
        begin
            if (pending_leds.size() == 0)
                note_error("result word with nothing expected");
            else
            begin
                want = pending_leds.pop_front();
                if (seen_s.led_drive != want.led_drive)
                    note_error($sformatf("led_drive got %b want %b",
                                         seen_s.led_drive, want.led_drive));
                if (seen_s.pwm_enabled != want.pwm_enabled)
                    note_error($sformatf("pwm_enabled got %b want %b",
                                         seen_s.pwm_enabled, want.pwm_enabled));
                if (seen_s.pwm_level != want.pwm_level)
                    note_error($sformatf("pwm_level got %0d want %0d",
                                         seen_s.pwm_level, want.pwm_level));
                if (seen_s.current_pattern != want.current_pattern)
                    note_error($sformatf("current_pattern got %0d want %0d",
                                         seen_s.current_pattern, want.current_pattern));
                if (seen_s.press_dropped != want.press_dropped)
                    note_error($sformatf("press_dropped got %b want %b",
                                         seen_s.press_dropped, want.press_dropped));
            end
            words_seen++;
        end
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("[led_pattern_mode_controller_core] ERROR");
        $finish;
    end

    initial
    begin
        script_row_t script[$];
        bit          drained;
        int          tick_pct;
        int          press_pct;
        bit          t;
        bit          p;
        logic [1:0]  b;
        logic [7:0]  deb;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        tick <= 1'b0;
        press <= 1'b0;
        button_id <= BTN_A;

        // shadow starts from the reset state
        cfg_copy = '{DEBOUNCE_RESET, CHASER_RESET, BLINK_RESET, REVERSE_RESET,
                     BREATHE_RESET, STEP_RESET};
        mode_q = PAT_CHASER;
        ms_count = 0;
        ms_since_press = 0;
        ev_count = 0;
        ev_head = 0;
        foreach (ev_ring[i])
            ev_ring[i] = BTN_A;
        fwd_pos = 2'd1;
        rev_pos = 2'd3;
        blink_lit = 1'b0;
        glow = 0;
        glow_up = 1'b1;
        led_q = 4'b0001;
        glow_held = 9'd0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        // defaults: idle word, then a press inside the debounce window
        script.push_back(known_row(1'b0, 1'b0, BTN_A, 4'b0001));
        script.push_back(known_row(1'b1, 1'b1, BTN_A, 4'b0001));
        // one-tick periods but for breathing, no debounce, a level step of 64
        script.push_back(reg_row(CFG_DEBOUNCE, 10'd0));
        script.push_back(reg_row(CFG_CHASER, 10'd1));
        script.push_back(reg_row(CFG_BLINK, 10'd1));
        script.push_back(reg_row(CFG_REVERSE, 10'd1));
        script.push_back(reg_row(CFG_BREATHE, 10'd1023));
        script.push_back(reg_row(CFG_STEP, 10'd64));
        script.push_back(known_row(1'b1, 1'b0, BTN_A, 4'b0010));
        // chaser, blink and reverse against every button, button three in between
        script.push_back(word_row(1'b1, 1'b1, BTN_B));
        script.push_back(word_row(1'b1, 1'b1, BTN_A));
        script.push_back(word_row(1'b1, 1'b1, BTN_C));
        script.push_back(word_row(1'b1, 1'b1, BTN_B));
        script.push_back(word_row(1'b1, 1'b1, BUTTON_NONE));
        script.push_back(word_row(1'b1, 1'b1, BTN_C));
        script.push_back(word_row(1'b1, 1'b1, BTN_B));
        script.push_back(word_row(1'b1, 1'b1, BTN_A));
        script.push_back(word_row(1'b1, 1'b1, BTN_A));
        script.push_back(word_row(1'b1, 1'b1, BTN_B));
        script.push_back(word_row(1'b1, 1'b1, BTN_C));
        // longest period: fill the event queue until a press is lost
        script.push_back(reg_row(CFG_REVERSE, 10'd1023));
        for (int i = 0; i < QUEUE_SLOTS + 1; i++)
            script.push_back(word_row(1'b1, 1'b1, 2'(i % 3)));
        // period lowered below the running count, then a zero period
        script.push_back(reg_row(CFG_REVERSE, 10'd4));
        script.push_back(word_row(1'b1, 1'b0, BTN_A));
        script.push_back(reg_row(CFG_REVERSE, 10'd0));
        script.push_back(word_row(1'b1, 1'b0, BTN_A));
        // debounce at saturation never lets a press through; zero step
        script.push_back(reg_row(CFG_DEBOUNCE, 10'd255));
        script.push_back(reg_row(CFG_STEP, 10'd0));
        script.push_back(reg_row(CFG_BREATHE, 10'd0));
        script.push_back(word_row(1'b1, 1'b1, BTN_C));

        drained = 1'b1;
        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                if (!drained)
                begin
                    wait_drained();
                    drained = 1'b1;
                end
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                send_word(script[i].w_tick, script[i].w_press, script[i].w_button,
                          script[i].typed, script[i].want);
                drained = 1'b0;
            end
        end

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            steady = (ph % 3 == 2);
            case (ph)
                0: deb = 8'd0;
                2: deb = 8'd254;
                5: deb = 8'd255;
                default: deb = 8'($urandom_range(0, 6));
            endcase
            write_reg(CFG_DEBOUNCE, {2'b00, deb});
            write_reg(CFG_CHASER, pick_period(ph));
            write_reg(CFG_BLINK, pick_period(ph));
            write_reg(CFG_REVERSE, pick_period(ph));
            write_reg(CFG_BREATHE, pick_period(ph));
            write_reg(CFG_STEP, 10'($urandom_range(0, 64)));
            tick_pct = $urandom_range(50, 95);
            press_pct = $urandom_range(20, 70);
            repeat (PHASE_WORDS)
            begin
                t = ($urandom_range(0, 99) < tick_pct);
                p = ($urandom_range(0, 99) < press_pct);
                if (p && $urandom_range(0, 7) == 0)
                    b = BUTTON_NONE;
                else if (p)
                    b = 2'($urandom_range(0, 2));
                else
                    b = 2'($urandom_range(0, 3));
                send_word(t, p, b, 1'b0, '0);
            end
        end

        // drain and close
        in_valid <= 1'b0;
        for (int w = 0; w < 10000 && pending_leds.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_leds.size() != 0)
            note_error($sformatf("%0d expected words never came", pending_leds.size()));
        if (fail_count == 0)
            $display("[led_pattern_mode_controller_core] OK");
        else
            $display("[led_pattern_mode_controller_core] ERROR");
        $finish;
    end

endmodule
